// ----- rtl/cbcms_pkg.sv -----
// ============================================================================
// cbcms_pkg
// Shared types, constants and helpers of the centre box color mask stats block.
// ============================================================================
package cbcms_pkg;

    localparam int MAX_DIM_DEF   = 4096;
    localparam int CHANNELS_DEF  = 4;

    localparam int CFG_W         = 13;
    localparam int CFG_DIM_LIMIT = (1 << CFG_W) - 1;

    localparam int WIDTH_RESET   = 320;
    localparam int HEIGHT_RESET  = 240;
    localparam int HALF_RESET    = 16;
    localparam int CHAN_A_RESET  = 2;
    localparam int CHAN_B_RESET  = 1;
    localparam int THR_RESET     = 0;

    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam int MEAN_W        = 17;
    localparam int COUNT_W       = 25;
    localparam int CENT_W        = 20;

    typedef logic [PADDR_W-3:0] reg_index_t;

    localparam reg_index_t REG_FRAME_WIDTH    = 3'd0;
    localparam reg_index_t REG_FRAME_HEIGHT   = 3'd1;
    localparam reg_index_t REG_BOX_HALF_SIZE  = 3'd2;
    localparam reg_index_t REG_CHANNEL_A      = 3'd3;
    localparam reg_index_t REG_CHANNEL_B      = 3'd4;
    localparam reg_index_t REG_DIFF_THRESHOLD = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0]  frame_width;
        logic [CFG_W-1:0]  frame_height;
        logic [CFG_W-1:0]  box_half_size;
        logic [1:0]        channel_a;
        logic [1:0]        channel_b;
        logic signed [8:0] diff_threshold;
    } cfg_regs_t;

    typedef struct packed {
        logic              in_box;
        logic              hit;
        logic              last;
        logic signed [8:0] diff;
    } pix_class_t;

    typedef enum logic [2:0] {
        BK_ACC,
        BK_MEAN_LOAD,
        BK_MEAN_WAIT,
        BK_CENT_LOAD,
        BK_CENT_WAIT,
        BK_PRESENT
    } back_state_t;

    // largest frame dimension the registers can hold
    function automatic int dim_limit(int max_dim);
        return (max_dim < CFG_DIM_LIMIT) ? max_dim : CFG_DIM_LIMIT;
    endfunction

    // largest dimension reachable, reset values included
    function automatic int dim_span(int max_dim);
        int m;
        m = dim_limit(max_dim);
        if (m < WIDTH_RESET) m = WIDTH_RESET;
        if (m < HEIGHT_RESET) m = HEIGHT_RESET;
        return m;
    endfunction

    function automatic logic [CFG_W-1:0] box_lo(logic [CFG_W-1:0] size,
                                                logic [CFG_W-1:0] half);
        logic [CFG_W-1:0] c;
        c = size >> 1;
        return (c > half) ? c - half : '0;
    endfunction

    function automatic logic [CFG_W-1:0] box_hi(logic [CFG_W-1:0] size,
                                                logic [CFG_W-1:0] half);
        logic [CFG_W-1:0] c;
        logic [CFG_W:0]   s;
        c = size >> 1;
        s = {1'b0, c} + {1'b0, half};
        return (s < {1'b0, size}) ? s[CFG_W-1:0] : size;
    endfunction

endpackage

// ----- rtl/cbcms_pix_if.sv -----
// ============================================================================
// cbcms_pix_if
// Pixel item channel: valid/ready handshake with four 8-bit channels.
// ============================================================================
interface cbcms_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;

    modport source (output valid, output chan0, output chan1, output chan2,
                    output chan3, input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2,
                    input chan3, output ready);
endinterface

// ----- rtl/cbcms_res_if.sv -----
// ============================================================================
// cbcms_res_if
// Result item channel: valid/ready handshake with the per-frame statistics.
// ============================================================================
interface cbcms_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [cbcms_pkg::MEAN_W-1:0] diff_mean_q8;
    logic [cbcms_pkg::COUNT_W-1:0]       box_area;
    logic [cbcms_pkg::COUNT_W-1:0]       hit_count;
    logic [cbcms_pkg::CENT_W-1:0]        x_centroid_q8;
    logic                                hit_found;

    modport source (output valid, output diff_mean_q8, output box_area,
                    output hit_count, output x_centroid_q8, output hit_found,
                    input ready);
    modport sink   (input valid, input diff_mean_q8, input box_area,
                    input hit_count, input x_centroid_q8, input hit_found,
                    output ready);
endinterface

// ----- rtl/cbcms_cfg.sv -----
// ============================================================================
// cbcms_cfg
// APB register file; a frame size write restarts the frame.
// ============================================================================
module cbcms_cfg #(
    parameter int MAX_DIM = cbcms_pkg::MAX_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbcms_pkg::PADDR_W-1:0]  paddr,
    input  logic [cbcms_pkg::PDATA_W-1:0]  pwdata,
    output logic [cbcms_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    output cbcms_pkg::cfg_regs_t           cfg,
    output logic                           restart
);

    localparam int CW = cbcms_pkg::CFG_W;
    localparam logic [CW-1:0] DIM_LIM = CW'(cbcms_pkg::dim_limit(MAX_DIM));

    cbcms_pkg::cfg_regs_t   cfg_reg;
    cbcms_pkg::cfg_regs_t   cfg_next;
    cbcms_pkg::reg_index_t  idx;
    logic                   wr;
    logic [CW-1:0]          dim_raw;
    logic [CW-1:0]          dim_clamped;

    assign pready  = 1'b1;
    assign idx     = paddr[cbcms_pkg::PADDR_W-1:2];
    assign wr      = psel && penable && pwrite && pready;
    assign dim_raw = pwdata[CW-1:0];
    assign cfg     = cfg_reg;

    always_comb
    begin
        if (dim_raw == '0)
            dim_clamped = CW'(1);
        else if (dim_raw > DIM_LIM)
            dim_clamped = DIM_LIM;
        else
            dim_clamped = dim_raw;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (wr)
        begin
            case (idx)
                cbcms_pkg::REG_FRAME_WIDTH:
                begin
                    cfg_next.frame_width = dim_clamped;
                    restart = 1'b1;
                end
                cbcms_pkg::REG_FRAME_HEIGHT:
                begin
                    cfg_next.frame_height = dim_clamped;
                    restart = 1'b1;
                end
                cbcms_pkg::REG_BOX_HALF_SIZE:  cfg_next.box_half_size  = pwdata[CW-1:0];
                cbcms_pkg::REG_CHANNEL_A:      cfg_next.channel_a      = pwdata[1:0];
                cbcms_pkg::REG_CHANNEL_B:      cfg_next.channel_b      = pwdata[1:0];
                cbcms_pkg::REG_DIFF_THRESHOLD: cfg_next.diff_threshold = pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            cbcms_pkg::REG_FRAME_WIDTH:    prdata = 32'(cfg_reg.frame_width);
            cbcms_pkg::REG_FRAME_HEIGHT:   prdata = 32'(cfg_reg.frame_height);
            cbcms_pkg::REG_BOX_HALF_SIZE:  prdata = 32'(cfg_reg.box_half_size);
            cbcms_pkg::REG_CHANNEL_A:      prdata = 32'(cfg_reg.channel_a);
            cbcms_pkg::REG_CHANNEL_B:      prdata = 32'(cfg_reg.channel_b);
            cbcms_pkg::REG_DIFF_THRESHOLD: prdata = {23'd0, cfg_reg.diff_threshold};
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width    <= CW'(cbcms_pkg::WIDTH_RESET);
            cfg_reg.frame_height   <= CW'(cbcms_pkg::HEIGHT_RESET);
            cfg_reg.box_half_size  <= CW'(cbcms_pkg::HALF_RESET);
            cfg_reg.channel_a      <= 2'(cbcms_pkg::CHAN_A_RESET);
            cfg_reg.channel_b      <= 2'(cbcms_pkg::CHAN_B_RESET);
            cfg_reg.diff_threshold <= 9'(cbcms_pkg::THR_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/cbcms_front.sv -----
// ============================================================================
// cbcms_front
// Accepts pixels, tracks raster position, classifies box membership and hits.
// ============================================================================
module cbcms_front #(
    parameter  int MAX_DIM  = cbcms_pkg::MAX_DIM_DEF,
    parameter  int CHANNELS = cbcms_pkg::CHANNELS_DEF,
    localparam int POS_W    = $clog2(cbcms_pkg::dim_span(MAX_DIM))
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cbcms_pix_if.sink             pix,
    input  cbcms_pkg::cfg_regs_t  cfg,
    input  logic                  restart,
    input  logic                  q_full,
    output logic                  q_push,
    output cbcms_pkg::pix_class_t q_cls,
    output logic [POS_W-1:0]      q_col
);

    localparam int CW = cbcms_pkg::CFG_W;

    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] row_reg;
    logic [7:0]       chans [4];
    logic [7:0]       val_a;
    logic [7:0]       val_b;
    logic [CW-1:0]    x0, x1, y0, y1;
    logic [CW-1:0]    col_ext, row_ext;
    logic [CW:0]      col_inc, row_inc;
    logic             col_wrap, row_wrap;
    logic             accept;

    assign pix.ready = !q_full;
    assign accept    = pix.valid && !q_full;
    assign q_push    = accept;
    assign q_col     = col_reg;

    assign chans[0] = pix.chan0;
    assign chans[1] = pix.chan1;
    assign chans[2] = pix.chan2;
    assign chans[3] = pix.chan3;

    assign val_a = (int'(cfg.channel_a) < CHANNELS) ? chans[cfg.channel_a] : 8'd0;
    assign val_b = (int'(cfg.channel_b) < CHANNELS) ? chans[cfg.channel_b] : 8'd0;

    assign x0 = cbcms_pkg::box_lo(cfg.frame_width, cfg.box_half_size);
    assign x1 = cbcms_pkg::box_hi(cfg.frame_width, cfg.box_half_size);
    assign y0 = cbcms_pkg::box_lo(cfg.frame_height, cfg.box_half_size);
    assign y1 = cbcms_pkg::box_hi(cfg.frame_height, cfg.box_half_size);

    assign col_ext  = CW'(col_reg);
    assign row_ext  = CW'(row_reg);
    assign col_inc  = {1'b0, col_ext} + (CW+1)'(1);
    assign row_inc  = {1'b0, row_ext} + (CW+1)'(1);
    assign col_wrap = col_inc >= {1'b0, cfg.frame_width};
    assign row_wrap = row_inc >= {1'b0, cfg.frame_height};

    always_comb
    begin
        q_cls.in_box = (col_ext >= x0) && (col_ext < x1) &&
                       (row_ext >= y0) && (row_ext < y1);
        q_cls.diff   = $signed({1'b0, val_a}) - $signed({1'b0, val_b});
        q_cls.hit    = q_cls.in_box && (q_cls.diff > cfg.diff_threshold);
        q_cls.last   = col_wrap && row_wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                if (row_wrap)
                    row_reg <= '0;
                else
                    row_reg <= row_reg + POS_W'(1);
            end
            else
            begin
                col_reg <= col_reg + POS_W'(1);
            end
        end
    end

endmodule

// ----- rtl/cbcms_queue.sv -----
// ============================================================================
// cbcms_queue
// Small FIFO between the classifying front and the accumulating back.
// ============================================================================
module cbcms_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = cbcms_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ----- rtl/cbcms_div.sv -----
// ============================================================================
// cbcms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module cbcms_div #(
    parameter int N = 46,
    parameter int M = 26
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [M-1:0] divisor,
    output logic         busy,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]     acc_reg;
    logic [M-1:0]     rem_reg;
    logic [M-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [M:0]       trial;
    logic [M:0]       trial_sub;
    logic             ge;

    assign trial     = {rem_reg, acc_reg[N-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign ge        = trial >= {1'b0, dsr_reg};
    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = acc_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[N-2:0], ge};
            rem_reg <= ge ? trial_sub[M-1:0] : trial[M-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(N);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/cbcms_back.sv -----
// ============================================================================
// cbcms_back
// Accumulates classified pixels and finishes each frame with two divisions.
// ============================================================================
module cbcms_back #(
    parameter  int MAX_DIM = cbcms_pkg::MAX_DIM_DEF,
    localparam int POS_W   = $clog2(cbcms_pkg::dim_span(MAX_DIM))
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cbcms_pkg::cfg_regs_t  cfg,
    input  logic                  restart,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  cbcms_pkg::pix_class_t q_cls,
    input  logic [POS_W-1:0]      q_col,
    cbcms_res_if.source           res
);

    localparam int CW      = cbcms_pkg::CFG_W;
    localparam int DIM_W   = $clog2(cbcms_pkg::dim_span(MAX_DIM) + 1);
    localparam int AREA_W  = 2 * DIM_W;
    localparam int DACC_W  = AREA_W + 9;
    localparam int MAG_W   = AREA_W + 8;
    localparam int XACC_W  = AREA_W + POS_W;
    localparam int DIV_N   = ((MAG_W > XACC_W) ? MAG_W : XACC_W) + 8;
    localparam int MEAN_W  = cbcms_pkg::MEAN_W;
    localparam int COUNT_W = cbcms_pkg::COUNT_W;
    localparam int CENT_W  = cbcms_pkg::CENT_W;

    cbcms_pkg::back_state_t state_reg;
    cbcms_pkg::back_state_t state_next;

    logic [DACC_W-1:0]  diff_acc_reg, diff_sum;
    logic [AREA_W-1:0]  hit_acc_reg, hit_sum;
    logic [XACC_W-1:0]  x_acc_reg, x_sum;
    logic [DACC_W-1:0]  fin_diff_reg;
    logic [AREA_W-1:0]  fin_hit_reg;
    logic [XACC_W-1:0]  fin_x_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [CENT_W-1:0]  cent_reg;

    logic               out_valid_reg;
    logic [MEAN_W-1:0]  out_mean_reg;
    logic [COUNT_W-1:0] out_area_reg;
    logic [COUNT_W-1:0] out_hit_reg;
    logic [CENT_W-1:0]  out_cent_reg;
    logic               out_found_reg;

    logic [CW-1:0]      x0, x1, y0, y1;
    logic [2*CW-1:0]    area_full;
    logic [DACC_W-1:0]  diff_ext;
    logic [DACC_W-1:0]  diff_negated;
    logic [MAG_W-1:0]   mag;
    logic               neg;
    logic [MEAN_W-1:0]  mean_mag;

    logic               load_fin, take_mean, take_cent, load_out, sel_cent;
    logic               div_start, div_busy, div_done;
    logic [DIV_N-1:0]   div_dividend, div_q;
    logic [AREA_W-1:0]  div_divisor;

    assign x0 = cbcms_pkg::box_lo(cfg.frame_width, cfg.box_half_size);
    assign x1 = cbcms_pkg::box_hi(cfg.frame_width, cfg.box_half_size);
    assign y0 = cbcms_pkg::box_lo(cfg.frame_height, cfg.box_half_size);
    assign y1 = cbcms_pkg::box_hi(cfg.frame_height, cfg.box_half_size);
    assign area_full = (2*CW)'(x1 - x0) * (2*CW)'(y1 - y0);

    assign diff_ext = {{(DACC_W-9){q_cls.diff[8]}}, q_cls.diff};
    assign diff_sum = diff_acc_reg + (q_cls.in_box ? diff_ext : '0);
    assign hit_sum  = hit_acc_reg + AREA_W'(q_cls.hit);
    assign x_sum    = x_acc_reg + (q_cls.hit ? XACC_W'(q_col) : '0);

    assign neg          = fin_diff_reg[DACC_W-1];
    assign diff_negated = '0 - fin_diff_reg;
    assign mag          = neg ? diff_negated[MAG_W-1:0] : fin_diff_reg[MAG_W-1:0];
    assign mean_mag     = div_q[MEAN_W-1:0];

    assign div_dividend = sel_cent ? DIV_N'({fin_x_reg, 8'd0}) : DIV_N'({mag, 8'd0});
    assign div_divisor  = sel_cent ? fin_hit_reg : area_reg;

    cbcms_div #(
        .N (DIV_N),
        .M (AREA_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cbcms_pkg::BK_ACC;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_fin   = 1'b0;
        take_mean  = 1'b0;
        take_cent  = 1'b0;
        load_out   = 1'b0;
        sel_cent   = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            cbcms_pkg::BK_ACC:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_cls.last)
                    begin
                        load_fin   = 1'b1;
                        state_next = cbcms_pkg::BK_MEAN_LOAD;
                    end
                end
            end
            cbcms_pkg::BK_MEAN_LOAD:
            begin
                div_start  = 1'b1;
                state_next = cbcms_pkg::BK_MEAN_WAIT;
            end
            cbcms_pkg::BK_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    take_mean  = 1'b1;
                    state_next = cbcms_pkg::BK_CENT_LOAD;
                end
            end
            cbcms_pkg::BK_CENT_LOAD:
            begin
                sel_cent   = 1'b1;
                div_start  = 1'b1;
                state_next = cbcms_pkg::BK_CENT_WAIT;
            end
            cbcms_pkg::BK_CENT_WAIT:
            begin
                if (div_done)
                begin
                    take_cent  = 1'b1;
                    state_next = cbcms_pkg::BK_PRESENT;
                end
            end
            cbcms_pkg::BK_PRESENT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    load_out   = 1'b1;
                    state_next = cbcms_pkg::BK_ACC;
                end
            end
            default: state_next = cbcms_pkg::BK_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_acc_reg <= '0;
            hit_acc_reg  <= '0;
            x_acc_reg    <= '0;
        end
        else if (restart || (q_pop && q_cls.last))
        begin
            diff_acc_reg <= '0;
            hit_acc_reg  <= '0;
            x_acc_reg    <= '0;
        end
        else if (q_pop)
        begin
            diff_acc_reg <= diff_sum;
            hit_acc_reg  <= hit_sum;
            x_acc_reg    <= x_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fin)
        begin
            fin_diff_reg <= diff_sum;
            fin_hit_reg  <= hit_sum;
            fin_x_reg    <= x_sum;
            area_reg     <= AREA_W'(area_full);
        end
        if (take_mean)
        begin
            if (area_reg == '0)
                mean_reg <= '0;
            else
                mean_reg <= neg ? -mean_mag : mean_mag;
        end
        if (take_cent)
            cent_reg <= (fin_hit_reg == '0) ? '0 : div_q[CENT_W-1:0];
        if (load_out)
        begin
            out_mean_reg  <= mean_reg;
            out_area_reg  <= COUNT_W'(area_reg);
            out_hit_reg   <= COUNT_W'(fin_hit_reg);
            out_cent_reg  <= cent_reg;
            out_found_reg <= fin_hit_reg != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    assign res.valid         = out_valid_reg;
    assign res.diff_mean_q8  = out_mean_reg;
    assign res.box_area      = out_area_reg;
    assign res.hit_count     = out_hit_reg;
    assign res.x_centroid_q8 = out_cent_reg;
    assign res.hit_found     = out_found_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == cbcms_pkg::BK_MEAN_WAIT ||
                      state_reg == cbcms_pkg::BK_CENT_WAIT))
        else $error("divider finished outside a wait state");

    a_result_from_present: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == cbcms_pkg::BK_PRESENT)
        else $error("result raised without a finished frame");

    a_present_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cbcms_pkg::BK_PRESENT && out_valid_reg && !res.ready)
        |=> state_reg == cbcms_pkg::BK_PRESENT)
        else $error("pending result overwritten");

endmodule

// ----- rtl/centre_box_color_mask_stats.sv -----
// ============================================================================
// centre_box_color_mask_stats
// Centre box channel-difference statistics over a raster frame of pixels.
// ============================================================================
// Throughput: one pixel item per cycle inside a frame while the back end is accumulating.
// After the last pixel the back end runs two serial DIV_N-bit divisions,
// mean then centroid (DIV_N = 46 at MAX_DIM 4096); the result is valid once
// BK_PRESENT loads the result register. Up to QUEUE_DEPTH pixels of the next
// frame enter meanwhile, then the input stalls until that register is loaded.
// Reset: asynchronous; registers return to defaults, positions and sums clear.
// ============================================================================
module centre_box_color_mask_stats #(
    parameter int MAX_DIM  = cbcms_pkg::MAX_DIM_DEF,
    parameter int CHANNELS = cbcms_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbcms_pkg::PADDR_W-1:0] paddr,
    input  logic [cbcms_pkg::PDATA_W-1:0] pwdata,
    output logic [cbcms_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    cbcms_pix_if.sink                     pix,
    cbcms_res_if.source                   res
);

    localparam int POS_W = $clog2(cbcms_pkg::dim_span(MAX_DIM));
    localparam int QW    = $bits(cbcms_pkg::pix_class_t) + POS_W;

    cbcms_pkg::cfg_regs_t  cfg;
    logic                  restart;
    logic                  q_push, q_pop, q_full, q_empty;
    cbcms_pkg::pix_class_t cls_in, cls_out;
    logic [POS_W-1:0]      col_in, col_out;
    logic [QW-1:0]         q_rdata;

    cbcms_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    cbcms_front #(
        .MAX_DIM  (MAX_DIM),
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix),
        .cfg     (cfg),
        .restart (restart),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cls   (cls_in),
        .q_col   (col_in)
    );

    cbcms_queue #(
        .WIDTH (QW),
        .DEPTH (cbcms_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({cls_in, col_in}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign cls_out = q_rdata[QW-1:POS_W];
    assign col_out = q_rdata[POS_W-1:0];

    cbcms_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (restart),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_cls   (cls_out),
        .q_col   (col_out),
        .res     (res)
    );

endmodule
